// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// Depends on nothing; the using module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mqttpp_pkg.sv
// Package for the MQTT PUBLISH byte parser: phase and role codes, status
// codes, field widths and the result record. Depends on nothing.
package mqttpp_pkg;

  localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

  localparam int unsigned LEN_W  = 28;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CNT_W  = 3;

  // Parser phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_TLEN    = 3'd2;
  localparam logic [2:0] PH_TOPIC   = 3'd3;
  localparam logic [2:0] PH_IDENT   = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  // Byte roles
  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_LENGTH  = 3'd1;
  localparam logic [2:0] ROLE_TLEN    = 3'd2;
  localparam logic [2:0] ROLE_TOPIC   = 3'd3;
  localparam logic [2:0] ROLE_IDENT   = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
  localparam logic [2:0] ROLE_SKIP    = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADLEN  = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  typedef struct packed {
    logic [7:0]        byte_out;
    logic [2:0]        role;
    logic [1:0]        qos_level;
    logic              retain_flag;
    logic [LEN_W-1:0]  remaining_length;
    logic [WORD_W-1:0] topic_length;
    logic [WORD_W-1:0] packet_ident;
    logic [LEN_W-1:0]  payload_length;
    logic              done_res;
    logic [1:0]        status;
  } res_t;

endpackage

// File: rtl/mqtt_publish_parser_unit.sv
// MQTT PUBLISH packet parser, one byte per request, top level.
// Depends on mqttpp_pkg and assert_macros.svh.
//
// Takes one packet byte per cycle while in_ready is high and returns one
// tagged result per byte: the byte itself, its role (header, length, topic
// length, topic, packet id, payload, ignored) and the fields decoded so far.
// The remaining length may take 1 to MAX_LENGTH_BYTES bytes. done_res marks
// the packet's last byte or the byte on which an error is found; status
// then says which error. After an error the bytes up to the next buffer_end
// are tagged as ignored. Throughput is one byte per cycle while in_ready is
// high: the whole per-byte update is a single pass of the phase logic from
// the state registers into the output stage. Results sit in a two-entry
// output stage (result register plus skid register), so a new byte is taken
// while one result is still waiting; in_ready drops only when both entries
// are full. There is no clearing pass after reset.
module mqtt_publish_parser_unit #(
  parameter int unsigned MAX_LENGTH_BYTES = mqttpp_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      byte_value,
  input  logic                            buffer_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      byte_out,
  output logic [2:0]                      role,
  output logic [1:0]                      qos_level,
  output logic                            retain_flag,
  output logic [mqttpp_pkg::LEN_W-1:0]    remaining_length,
  output logic [mqttpp_pkg::WORD_W-1:0]   topic_length,
  output logic [mqttpp_pkg::WORD_W-1:0]   packet_ident,
  output logic [mqttpp_pkg::LEN_W-1:0]    payload_length,
  output logic                            done_res,
  output logic [1:0]                      status
);
  import mqttpp_pkg::*;

  // Parser state
  logic [2:0]        phase, phase_next;
  logic [LEN_W-1:0]  length_accum, length_accum_next;
  logic [CNT_W-1:0]  length_byte_count, length_byte_count_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [WORD_W-1:0] topic_len_reg, topic_len_reg_next;
  logic [WORD_W-1:0] topic_count, topic_count_next;
  logic [1:0]        qos_reg, qos_reg_next;
  logic              retain_reg, retain_reg_next;
  logic [WORD_W-1:0] ident_reg, ident_reg_next;
  logic [LEN_W-1:0]  payload_count, payload_count_next;
  logic [1:0]        error_code, error_code_next;

  // Output stage: result register and skid register
  res_t out_reg;
  res_t skid_reg;
  logic skid_valid;
  res_t res_next;

  logic accept;
  logic out_take;

  // Per-byte decode helpers
  logic [LEN_W-1:0]  left_dec;
  logic [LEN_W-1:0]  length_group;
  logic [LEN_W-1:0]  accum_new;
  logic [CNT_W-1:0]  count_inc;
  logic [WORD_W:0]   need;
  logic              err_set;
  logic [1:0]        err_code;
  logic              err_end;
  logic              finish;
  logic              topic_done;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // One pass of the phase logic: state after this byte and its result.
  always_comb begin
    phase_next             = phase;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    bytes_left_next        = bytes_left;
    topic_len_reg_next     = topic_len_reg;
    topic_count_next       = topic_count;
    qos_reg_next           = qos_reg;
    retain_reg_next        = retain_reg;
    ident_reg_next         = ident_reg;
    payload_count_next     = payload_count;
    error_code_next        = error_code;

    res_next          = '0;
    res_next.byte_out = byte_value;
    res_next.role     = ROLE_SKIP;
    res_next.status   = ST_OK;

    err_set    = 1'b0;
    err_code   = ST_OK;
    err_end    = 1'b0;
    finish     = 1'b0;
    topic_done = 1'b0;
    need       = '0;

    // Body bytes count down what is left, saturating at zero.
    left_dec  = (bytes_left != '0) ? bytes_left - LEN_W'(1) : bytes_left;
    count_inc = length_byte_count + CNT_W'(1);

    // Place the 7-bit group of a length byte by its position.
    case (length_byte_count[1:0])
      2'd0:    length_group = {21'd0, byte_value[6:0]};
      2'd1:    length_group = {14'd0, byte_value[6:0], 7'd0};
      2'd2:    length_group = {7'd0, byte_value[6:0], 14'd0};
      default: length_group = {byte_value[6:0], 21'd0};
    endcase
    accum_new = length_accum | length_group;

    case (phase)
      PH_HEADER: begin
        // Start a fresh packet: clear everything, load QoS and retain.
        res_next.role          = ROLE_HEADER;
        length_accum_next      = '0;
        length_byte_count_next = '0;
        bytes_left_next        = '0;
        topic_len_reg_next     = '0;
        topic_count_next       = '0;
        ident_reg_next         = '0;
        payload_count_next     = '0;
        error_code_next        = ST_OK;
        qos_reg_next           = byte_value[2:1];
        retain_reg_next        = byte_value[0];
        if (buffer_end) begin
          err_set  = 1'b1;
          err_code = ST_SHORT;
          err_end  = 1'b1;
        end else begin
          phase_next = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        res_next.role          = ROLE_LENGTH;
        length_accum_next      = accum_new;
        length_byte_count_next = count_inc;
        if (byte_value[7]) begin
          if (count_inc >= CNT_W'(MAX_LENGTH_BYTES)) begin
            err_set  = 1'b1;
            err_code = ST_BADLEN;
            err_end  = buffer_end;
          end else if (buffer_end) begin
            err_set  = 1'b1;
            err_code = ST_SHORT;
            err_end  = 1'b1;
          end
        end else begin
          bytes_left_next        = accum_new;
          length_byte_count_next = '0;
          if (accum_new < LEN_W'(2)) begin
            err_set  = 1'b1;
            err_code = ST_OVERRUN;
            err_end  = buffer_end;
          end else if (buffer_end) begin
            err_set  = 1'b1;
            err_code = ST_SHORT;
            err_end  = 1'b1;
          end else begin
            phase_next = PH_TLEN;
          end
        end
      end
      PH_TLEN: begin
        res_next.role   = ROLE_TLEN;
        bytes_left_next = left_dec;
        if (length_byte_count == '0) begin
          topic_len_reg_next     = {byte_value, 8'd0};
          length_byte_count_next = CNT_W'(1);
        end else begin
          topic_len_reg_next     = topic_len_reg | {8'd0, byte_value};
          length_byte_count_next = '0;
        end
        need = {1'b0, topic_len_reg_next} + ((qos_reg != 2'd0) ? 17'd2 : 17'd0);
        if (buffer_end && left_dec != '0) begin
          err_set  = 1'b1;
          err_code = ST_SHORT;
          err_end  = 1'b1;
        end else if (length_byte_count != '0) begin
          // Low byte: check that topic and id fit what is left of the body.
          if ({11'd0, need} > left_dec) begin
            err_set  = 1'b1;
            err_code = ST_OVERRUN;
            err_end  = buffer_end;
          end else if (topic_len_reg_next != '0) begin
            phase_next = PH_TOPIC;
          end else begin
            topic_done = 1'b1;
          end
        end
      end
      PH_TOPIC: begin
        res_next.role    = ROLE_TOPIC;
        topic_count_next = topic_count + WORD_W'(1);
        bytes_left_next  = left_dec;
        if (buffer_end && left_dec != '0) begin
          err_set  = 1'b1;
          err_code = ST_SHORT;
          err_end  = 1'b1;
        end else if (topic_count_next == topic_len_reg) begin
          topic_done = 1'b1;
        end
      end
      PH_IDENT: begin
        res_next.role   = ROLE_IDENT;
        bytes_left_next = left_dec;
        if (length_byte_count == '0) begin
          ident_reg_next         = {byte_value, 8'd0};
          length_byte_count_next = CNT_W'(1);
        end else begin
          ident_reg_next         = ident_reg | {8'd0, byte_value};
          length_byte_count_next = '0;
        end
        if (buffer_end && left_dec != '0) begin
          err_set  = 1'b1;
          err_code = ST_SHORT;
          err_end  = 1'b1;
        end else if (length_byte_count != '0) begin
          if (left_dec == '0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_next.role      = ROLE_PAYLOAD;
        payload_count_next = payload_count + LEN_W'(1);
        bytes_left_next    = left_dec;
        if (buffer_end && left_dec != '0) begin
          err_set  = 1'b1;
          err_code = ST_SHORT;
          err_end  = 1'b1;
        end else if (left_dec == '0) begin
          finish = 1'b1;
        end
      end
      default: begin
        // Drop bytes after an error until the buffer ends; repeat the code.
        res_next.role   = ROLE_SKIP;
        res_next.status = error_code;
        phase_next      = buffer_end ? PH_HEADER : PH_SKIP;
      end
    endcase

    // Topic finished: packet id next, else payload or end of packet.
    if (topic_done) begin
      if (qos_reg != 2'd0) begin
        phase_next = PH_IDENT;
      end else if (left_dec == '0) begin
        finish = 1'b1;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    if (finish) begin
      res_next.done_res = 1'b1;
      res_next.status   = ST_OK;
      phase_next        = PH_HEADER;
    end

    if (err_set) begin
      error_code_next   = err_code;
      res_next.status   = err_code;
      res_next.done_res = 1'b1;
      phase_next        = err_end ? PH_HEADER : PH_SKIP;
    end

    res_next.qos_level        = qos_reg_next;
    res_next.retain_flag      = retain_reg_next;
    res_next.remaining_length = length_accum_next;
    res_next.topic_length     = topic_len_reg_next;
    res_next.packet_ident     = ident_reg_next;
    res_next.payload_length   = payload_count_next;
  end

  // Advance the parser state on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      length_accum      <= '0;
      length_byte_count <= '0;
      bytes_left        <= '0;
      topic_len_reg     <= '0;
      topic_count       <= '0;
      qos_reg           <= '0;
      retain_reg        <= '0;
      ident_reg         <= '0;
      payload_count     <= '0;
      error_code        <= ST_OK;
    end else if (accept) begin
      phase             <= phase_next;
      length_accum      <= length_accum_next;
      length_byte_count <= length_byte_count_next;
      bytes_left        <= bytes_left_next;
      topic_len_reg     <= topic_len_reg_next;
      topic_count       <= topic_count_next;
      qos_reg           <= qos_reg_next;
      retain_reg        <= retain_reg_next;
      ident_reg         <= ident_reg_next;
      payload_count     <= payload_count_next;
      error_code        <= error_code_next;
    end
  end

  // Output stage control: hold a new result in the skid register when the
  // result register is still waiting, refill from the skid when it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid && !out_ready) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (out_valid && !out_ready) begin
        skid_reg <= res_next;
      end else begin
        out_reg <= res_next;
      end
    end
  end

  assign byte_out         = out_reg.byte_out;
  assign role             = out_reg.role;
  assign qos_level        = out_reg.qos_level;
  assign retain_flag      = out_reg.retain_flag;
  assign remaining_length = out_reg.remaining_length;
  assign topic_length     = out_reg.topic_length;
  assign packet_ident     = out_reg.packet_ident;
  assign payload_length   = out_reg.payload_length;
  assign done_res         = out_reg.done_res;
  assign status           = out_reg.status;

`include "assert_macros.svh"

  // Skid entry is only ever filled behind a waiting result.
  `ASSERT_IMPLIES(a_skid_behind_out, skid_valid, out_valid, "skid full with result register empty")
  // A byte taken while the result waits must land in the skid register.
  `ASSERT_NEXT(a_skid_fill, accept && out_valid && !out_ready, skid_valid, "stalled result lost")
  // Skipping bytes only ever follows a flagged error.
  `ASSERT_IMPLIES(a_skip_has_error, phase == PH_SKIP, error_code != ST_OK, "skip phase without error")
  // A nonzero status is either the flagging byte or an ignored byte.
  `ASSERT_IMPLIES(a_status_role, out_valid && status != ST_OK, done_res || role == ROLE_SKIP, "error status on ordinary byte")

endmodule
